// File: design/dapa_pkg.sv
// shared types and constants of the address pool allocator
package dapa_pkg;

    localparam int OP_W       = 2;
    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;
    localparam int LEASE_W    = 16;
    localparam int ST_W       = 2;
    localparam int RC_W       = 2;
    localparam int CNT_CFG_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_PAD_W    = IN_TDATA_W - OP_W - MAC_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RC_W - IP_W;

    localparam logic [LEASE_W-1:0] DEFAULT_LEASE = 16'd3600;

    localparam logic [OP_W-1:0] OP_OFFER   = 2'd0;
    localparam logic [OP_W-1:0] OP_CONFIRM = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

    localparam logic [RC_W-1:0] RC_OK        = 2'd0;
    localparam logic [RC_W-1:0] RC_NO_FREE   = 2'd1;
    localparam logic [RC_W-1:0] RC_PENDING   = 2'd2;
    localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd3;

    localparam logic [ST_W-1:0] ST_FREE     = 2'd0;
    localparam logic [ST_W-1:0] ST_PENDING  = 2'd1;
    localparam logic [ST_W-1:0] ST_RESERVED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_IP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE   = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [MAC_W-1:0]   mac;
        logic [LEASE_W-1:0] lease;
    } t_entry;

    typedef struct packed {
        logic clr;    // clear one pool entry
        logic start;  // capture a new item
        logic step;   // advance the scan by one entry
        logic load;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic done;      // scan finished, result captured at this edge
        logic clr_last;  // last entry of the clearing pass
    } t_sts;

endpackage

// File: design/dapa_dp.sv
// datapath: pool memory, configuration registers, scan pipeline and result
module dapa_dp import dapa_pkg::*; #(
    parameter int POOL_SIZE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_op,
    input  logic [MAC_W-1:0]      i_mac,
    output logic [RC_W-1:0]       o_res_code,
    output logic [IP_W-1:0]       o_res_ip
);

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam int CMP_W = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;

    t_entry mem [POOL_SIZE];

    logic [IP_W-1:0]      r_base;
    logic [CNT_CFG_W-1:0] r_count;
    logic [LEASE_W-1:0]   r_lease_cfg;

    logic [OP_W-1:0]  r_op;
    logic [MAC_W-1:0] r_mac;
    logic [CNT_W-1:0] r_lim;
    logic [CNT_W-1:0] r_idx;
    logic             r_ev_vld;
    logic [IDX_W-1:0] r_ev_idx;
    t_entry           r_rd_data;
    logic [RC_W-1:0]  r_code;
    logic [IP_W-1:0]  r_ip;

    logic [CNT_W-1:0]   lim_cfg;
    logic [CNT_W-1:0]   n_lim;
    logic               issue;
    logic               mac_eq;
    logic               hit;
    logic [RC_W-1:0]    hit_code;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic [LEASE_W-1:0] lease_dec;
    logic               done;
    logic [RC_W-1:0]    n_code;
    logic [IP_W-1:0]    n_ip;

    // count above the pool size acts as the pool size
    assign lim_cfg = (CMP_W'(r_count) > CMP_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE)
                                                          : CNT_W'(r_count);
    assign n_lim   = (i_op == OP_TICK) ? CNT_W'(POOL_SIZE) : lim_cfg;

    assign issue     = i_cmd.step && (r_idx < r_lim);
    assign mac_eq    = (r_rd_data.mac == r_mac);
    assign lease_dec = r_rd_data.lease - LEASE_W'(1);

    always_comb begin
        hit      = 1'b0;
        hit_code = RC_OK;
        wr_en    = 1'b0;
        wr_addr  = r_ev_idx;
        wr_data  = r_rd_data;
        if (i_cmd.clr) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[IDX_W-1:0];
            wr_data = '0;
        end else if (i_cmd.step && r_ev_vld) begin
            unique case (r_op)
                OP_OFFER: begin
                    if (r_rd_data.status == ST_FREE) begin
                        hit            = 1'b1;
                        wr_en          = 1'b1;
                        wr_data.status = ST_PENDING;
                        wr_data.mac    = r_mac;
                        wr_data.lease  = r_lease_cfg;
                    end else if (r_rd_data.status == ST_PENDING && mac_eq) begin
                        hit      = 1'b1;
                        hit_code = RC_PENDING;
                    end
                end
                OP_CONFIRM: begin
                    if ((r_rd_data.status == ST_PENDING ||
                         r_rd_data.status == ST_RESERVED) && mac_eq) begin
                        hit            = 1'b1;
                        wr_en          = 1'b1;
                        wr_data.status = ST_RESERVED;
                        wr_data.lease  = r_lease_cfg;
                    end
                end
                OP_LOOKUP: begin
                    if (r_rd_data.status != ST_FREE && mac_eq) begin
                        hit = 1'b1;
                    end
                end
                OP_TICK: begin
                    // count down, expire to free on reaching zero
                    if (r_rd_data.lease != '0) begin
                        wr_en         = 1'b1;
                        wr_data.lease = lease_dec;
                        if (lease_dec == '0) begin
                            wr_data.status = ST_FREE;
                        end
                    end
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    assign done = i_cmd.step && (hit || (!r_ev_vld && (r_idx >= r_lim)));

    always_comb begin
        if (hit) begin
            n_code = hit_code;
            n_ip   = (hit_code == RC_OK) ? (r_base + IP_W'(r_ev_idx)) : '0;
        end else begin
            n_code = (r_op == OP_OFFER) ? RC_NO_FREE : RC_NOT_FOUND;
            n_ip   = '0;
        end
    end

    // pool memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_count     <= '0;
            r_lease_cfg <= DEFAULT_LEASE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_IP: r_base      <= i_cfg_data;
                CFG_COUNT:   r_count     <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_LEASE:   r_lease_cfg <= i_cfg_data[LEASE_W-1:0];
                default:     r_base      <= r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ev_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx    <= '0;
            r_ev_vld <= 1'b0;
        end else if (i_cmd.clr || issue) begin
            r_idx    <= r_idx + CNT_W'(1);
            r_ev_vld <= issue;
        end else if (i_cmd.step) begin
            r_ev_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_op;
            r_mac <= i_mac;
            r_lim <= n_lim;
        end
        if (issue) begin
            r_ev_idx <= r_idx[IDX_W-1:0];
        end
        if (done) begin
            r_code <= n_code;
            r_ip   <= n_ip;
        end
    end

    assign o_sts.done     = done;
    assign o_sts.clr_last = (r_idx == CNT_W'(POOL_SIZE - 1));
    assign o_res_code     = r_code;
    assign o_res_ip       = r_ip;

endmodule

// File: design/dapa_ctrl.sv
// controller: clearing pass, item intake, scan sequencing and result hand-off
module dapa_ctrl import dapa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_free,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                o_cmd.load = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/dhcp_address_pool_allocator.sv
// top level of the address pool allocator: channels, output register, checks
//
// input stream (s_axis): one transaction per request; tdata carries the
//   operation (offer, confirm, lookup, one-second tick) and the client mac
// output stream (m_axis): exactly one transaction per request, in order,
//   carrying the result code and the address (zero unless the code is ok)
// config channel: index 0 base address, 1 entry count, 2 lease length;
//   other indexes are taken and dropped; it is to be written only while the
//   block is idle, which the user must keep to: the block does not enforce it
// timing: requests are handled one at a time; a request scans the pool
//   memory one entry per cycle through its single read port, up to the
//   active entry count (a tick always walks all POOL_SIZE entries), and a
//   hit on entry k ends the scan there; the next request can be taken in
//   the cycle after the result is loaded
// reset: after i_rst_n is released the pool memory is cleared in a pass of
//   all POOL_SIZE entries, during which no request is taken; config is taken
// stall: the output register holds a finished result until it is taken;
//   the next request is accepted meanwhile, and its result waits in the
//   datapath until the output register frees
module dhcp_address_pool_allocator import dapa_pkg::*; #(
    parameter int POOL_SIZE = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // op [1:0], client_mac [49:2], zeros
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // result_code [1:0], ip_addr [33:2], zeros
);

    t_cmd            cmd;
    t_sts            sts;
    logic [RC_W-1:0] res_code;
    logic [IP_W-1:0] res_ip;
    logic            out_free;
    logic            r_out_vld;
    logic [RC_W-1:0] r_out_code;
    logic [IP_W-1:0] r_out_ip;

    // config is always taken, the datapath applies it at once
    assign o_cfg_ready = 1'b1;

    // output register frees when empty or drained at this edge
    assign out_free = !r_out_vld || i_m_axis_tready;

    dapa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_axis_tready)
    );

    dapa_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_s_axis_tdata[OP_W-1:0]),
        .i_mac       (i_s_axis_tdata[OP_W +: MAC_W]),
        .o_res_code  (res_code),
        .o_res_ip    (res_ip)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load) begin
            r_out_code <= res_code;
            r_out_ip   <= res_ip;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_ip, r_out_code};

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!r_out_vld || i_m_axis_tready))
        else $error("output register overwritten");

    // only one request in flight: no intake right after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second request taken while one is in flight");

    // address is zero unless the code is ok
    a_ip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_code != RC_OK) |-> (r_out_ip == '0))
        else $error("address given with a failing code");

    // intake stays shut right after a scan has finished
    a_load_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.done |=> !o_s_axis_tready)
        else $error("intake reopened before result hand-off");

endmodule
